>>> hdl/lbss_pkg.sv
package lbss_pkg;

    // Timeline storage size and derived widths.
    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int STEP_W       = 4;

    // Lead-in off time that opens a reserve pause.
    localparam logic [CFG_W-1:0] PAUSE_LEAD_MS = 16'd200;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NORMAL_PERIOD = 3'd0;
    localparam logic [2:0] CFG_IDENTIFY_HALF = 3'd1;
    localparam logic [2:0] CFG_LONG_PULSE    = 3'd2;
    localparam logic [2:0] CFG_SHORT_PULSE   = 3'd3;
    localparam logic [2:0] CFG_PULSE_GAP     = 3'd4;
    localparam logic [2:0] CFG_SERIES_PAUSE  = 3'd5;
    localparam logic [2:0] CFG_RESERVE_TICK  = 3'd6;
    localparam logic [2:0] CFG_RESERVE_GAP   = 3'd7;

    // Scene codes.
    localparam logic [2:0] SC_NORMAL   = 3'd0;
    localparam logic [2:0] SC_AUTO_ISO = 3'd1;
    localparam logic [2:0] SC_IDENTIFY = 3'd2;
    localparam logic [2:0] SC_SHORT1   = 3'd3;
    localparam logic [2:0] SC_SHORT2   = 3'd4;
    localparam logic [2:0] SC_SHORT_T  = 3'd5;
    localparam logic [2:0] SC_OPEN_MAIN = 3'd6;
    localparam logic [2:0] SC_OPEN_T   = 3'd7;

    // Input action codes.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] now_ms;
        logic [2:0]        scene;
        logic              reserve;
    } t_in_word;

    typedef struct packed {
        logic              led_level;
        logic              level_event;
        logic [TIME_W-1:0] delay_ms;
    } t_out_word;

    typedef struct packed {
        logic [CFG_W-1:0] normal_period_ms;
        logic [CFG_W-1:0] identify_half_ms;
        logic [CFG_W-1:0] long_pulse_ms;
        logic [CFG_W-1:0] short_pulse_ms;
        logic [CFG_W-1:0] pulse_gap_ms;
        logic [CFG_W-1:0] series_pause_ms;
        logic [CFG_W-1:0] reserve_tick_ms;
        logic [CFG_W-1:0] reserve_gap_ms;
    } t_cfg;

    // One stored timeline segment.
    typedef struct packed {
        logic              on;
        logic [TIME_W-1:0] dur;
    } t_seg;

    // Where the duration of one pattern step comes from.
    typedef enum logic [3:0] {
        SRC_PERIOD,
        SRC_IDENT,
        SRC_LONG,
        SRC_SHORT,
        SRC_GAP,
        SRC_PAUSE,
        SRC_TICK,
        SRC_RGAP,
        SRC_LEAD,
        SRC_PAUSE_TAIL,
        SRC_NORMAL_TAIL
    } t_src;

    typedef struct packed {
        logic valid;
        logic on;
        t_src src;
    } t_push;

    // Request and response of the modulo unit.
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] rem;
    } t_mod_rsp;

    // Pattern step k of a scene: level and duration source, or not valid past the end.
    function automatic t_push push_at(input logic [2:0] scene, input logic reserve,
                                      input logic [STEP_W-1:0] k);
        t_push             p;
        logic              long_first;
        logic              pulse_scene;
        logic [2:0]        shorts;
        logic [STEP_W-1:0] plen;
        logic [STEP_W-1:0] j;
        p           = '{valid: 1'b0, on: 1'b0, src: SRC_GAP};
        long_first  = 1'b0;
        pulse_scene = 1'b0;
        shorts      = 3'd0;
        unique case (scene)
            SC_NORMAL: begin
                if (reserve) begin
                    unique case (k)
                        4'd0: p = '{valid: 1'b1, on: 1'b1, src: SRC_TICK};
                        4'd1: p = '{valid: 1'b1, on: 1'b0, src: SRC_RGAP};
                        4'd2: p = '{valid: 1'b1, on: 1'b1, src: SRC_TICK};
                        4'd3: p = '{valid: 1'b1, on: 1'b0, src: SRC_NORMAL_TAIL};
                        default: p = '{valid: 1'b0, on: 1'b0, src: SRC_GAP};
                    endcase
                end
            end
            SC_AUTO_ISO: begin
                if (k == '0) begin
                    p = '{valid: 1'b1, on: 1'b1, src: SRC_PERIOD};
                end
            end
            SC_IDENTIFY: begin
                if (k == '0) begin
                    p = '{valid: 1'b1, on: 1'b1, src: SRC_IDENT};
                end else if (k == STEP_W'(1)) begin
                    p = '{valid: 1'b1, on: 1'b0, src: SRC_IDENT};
                end
            end
            SC_SHORT1: begin
                pulse_scene = 1'b1;
                shorts      = 3'd1;
            end
            SC_SHORT2: begin
                pulse_scene = 1'b1;
                shorts      = 3'd2;
            end
            SC_SHORT_T: begin
                pulse_scene = 1'b1;
                shorts      = 3'd3;
            end
            SC_OPEN_MAIN: begin
                pulse_scene = 1'b1;
                long_first  = 1'b1;
                shorts      = 3'd2;
            end
            SC_OPEN_T: begin
                pulse_scene = 1'b1;
                long_first  = 1'b1;
                shorts      = 3'd3;
            end
        endcase
        if (pulse_scene) begin
            // Pulses alternate with gaps; the series has no gap after its last pulse.
            plen = STEP_W'(2) * (STEP_W'(shorts) + STEP_W'(long_first)) - STEP_W'(1);
            if (k < plen) begin
                p.valid = 1'b1;
                p.on    = ~k[0];
                if (k[0]) begin
                    p.src = SRC_GAP;
                end else if (k == '0 && long_first) begin
                    p.src = SRC_LONG;
                end else begin
                    p.src = SRC_SHORT;
                end
            end else begin
                j = k - plen;
                if (!reserve) begin
                    if (j == '0) begin
                        p = '{valid: 1'b1, on: 1'b0, src: SRC_PAUSE};
                    end
                end else begin
                    unique case (j)
                        4'd0: p = '{valid: 1'b1, on: 1'b0, src: SRC_LEAD};
                        4'd1: p = '{valid: 1'b1, on: 1'b1, src: SRC_TICK};
                        4'd2: p = '{valid: 1'b1, on: 1'b0, src: SRC_RGAP};
                        4'd3: p = '{valid: 1'b1, on: 1'b1, src: SRC_TICK};
                        4'd4: p = '{valid: 1'b1, on: 1'b0, src: SRC_PAUSE_TAIL};
                        default: p = '{valid: 1'b0, on: 1'b0, src: SRC_GAP};
                    endcase
                end
            end
        end
        return p;
    endfunction

    // Duration of one pattern step in ms; the tails clamp at zero.
    function automatic logic [CFG_W-1:0] src_ms(input t_cfg cfg, input t_src src);
        logic [CFG_W+2:0]  need;
        logic [CFG_W-1:0]  ms;
        need = '0;
        ms   = '0;
        unique case (src)
            SRC_PERIOD: ms = cfg.normal_period_ms;
            SRC_IDENT:  ms = cfg.identify_half_ms;
            SRC_LONG:   ms = cfg.long_pulse_ms;
            SRC_SHORT:  ms = cfg.short_pulse_ms;
            SRC_GAP:    ms = cfg.pulse_gap_ms;
            SRC_PAUSE:  ms = cfg.series_pause_ms;
            SRC_TICK:   ms = cfg.reserve_tick_ms;
            SRC_RGAP:   ms = cfg.reserve_gap_ms;
            SRC_LEAD:   ms = PAUSE_LEAD_MS;
            SRC_PAUSE_TAIL: begin
                need = (CFG_W+3)'(PAUSE_LEAD_MS) + ((CFG_W+3)'(cfg.reserve_tick_ms) << 1)
                     + (CFG_W+3)'(cfg.reserve_gap_ms);
                if ((CFG_W+3)'(cfg.series_pause_ms) > need) begin
                    ms = CFG_W'((CFG_W+3)'(cfg.series_pause_ms) - need);
                end
            end
            SRC_NORMAL_TAIL: begin
                need = ((CFG_W+3)'(cfg.reserve_tick_ms) << 1)
                     + (CFG_W+3)'(cfg.reserve_gap_ms);
                if ((CFG_W+3)'(cfg.normal_period_ms) > need) begin
                    ms = CFG_W'((CFG_W+3)'(cfg.normal_period_ms) - need);
                end
            end
            default: ms = '0;
        endcase
        return ms;
    endfunction

endpackage

>>> hdl/lbss_mod_unit.sv
// Restoring remainder unit: one quotient bit per cycle.
module lbss_mod_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbss_pkg::t_mod_req i_req,
    output lbss_pkg::t_mod_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [$clog2(lbss_pkg::TIME_W)-1:0] r_cnt;
    logic [lbss_pkg::TIME_W-1:0]    r_rem;
    logic [lbss_pkg::TIME_W-1:0]    r_dvd;
    logic [lbss_pkg::TIME_W-1:0]    r_div;

    logic [lbss_pkg::TIME_W:0]      w_trial;
    logic [lbss_pkg::TIME_W:0]      w_diff;
    logic [lbss_pkg::TIME_W-1:0]    w_next;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    assign w_trial = {r_rem, r_dvd[lbss_pkg::TIME_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_next  = w_diff[lbss_pkg::TIME_W] ? w_trial[lbss_pkg::TIME_W-1:0]
                                              : w_diff[lbss_pkg::TIME_W-1:0];

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_next;
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

>>> hdl/led_blink_scene_sequencer_unit.sv
// LED blink scene sequencer.
// Input channel (i_in_valid / o_in_stall, payload i_in_word) takes two kinds of
// word. A set word with a new scene or reserve flag rebuilds the on/off timeline,
// one pattern step per cycle, restarts the cycle at now_ms and gives no result;
// an unchanged set word is dropped.
// A tick word gives one result word on o_out_valid / i_out_stall: the LED level,
// a flag that the level must be driven anew, and the ms to the next change.
// On an empty timeline a tick goes straight to the output register. Otherwise,
// when the elapsed time has passed the cycle length, it first goes through the
// 32-step remainder unit; it then walks the segments (segment memory read, add,
// compare for each) and loads the output register.
// The block takes one word at a time and stalls its input until that word is done.
// A finished result waits in the output register while the receiver stalls; the
// block then accepts the next word, and only a following result waits for the slot.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) writes one 16-bit
// register per word and takes effect at the next rebuild.
// Reset restores register defaults, selects the normal scene without reserve and
// an empty timeline; no memory clearing is needed.
module led_blink_scene_sequencer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lbss_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lbss_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [lbss_pkg::CFG_W-1:0] i_cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_BUILD = 8'b0000_0010,
        ST_CHECK = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_RD    = 8'b0001_0000,
        ST_ADD   = 8'b0010_0000,
        ST_TST   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } t_state;

    t_state                          r_state, n_state;
    lbss_pkg::t_cfg                  r_cfg;
    logic [2:0]                      r_scene, n_scene;
    logic                            r_reserve, n_reserve;
    logic                            r_level_valid, n_level_valid;
    logic                            r_last_level, n_last_level;
    logic [lbss_pkg::TIME_W-1:0]     r_cycle_start, n_cycle_start;
    logic [lbss_pkg::TIME_W-1:0]     r_cycle_len, n_cycle_len;
    logic [lbss_pkg::CNT_W-1:0]      r_seg_count, n_seg_count;
    logic                            r_out_valid, n_out_valid;
    lbss_pkg::t_out_word             r_out_word, n_out_word;

    logic [lbss_pkg::STEP_W-1:0]     r_step, n_step;
    lbss_pkg::t_seg                  r_pend, n_pend;
    logic [lbss_pkg::TIME_W-1:0]     r_now, n_now;
    logic [lbss_pkg::TIME_W-1:0]     r_elapsed, n_elapsed;
    logic [lbss_pkg::TIME_W-1:0]     r_acc, n_acc;
    logic [lbss_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic                            r_cur_on, n_cur_on;
    logic                            r_emit_on, n_emit_on;
    logic [lbss_pkg::TIME_W-1:0]     r_emit_delay, n_emit_delay;

    lbss_pkg::t_seg                  r_mem [lbss_pkg::MAX_SEGMENTS];
    lbss_pkg::t_seg                  r_rd;
    logic                            w_mem_we;
    logic [lbss_pkg::IDX_W-1:0]      w_mem_addr;

    lbss_pkg::t_push                 w_push;
    logic [lbss_pkg::CFG_W-1:0]      w_ms;
    logic [lbss_pkg::TIME_W-1:0]     w_sum;
    logic [lbss_pkg::TIME_W-1:0]     w_rem;
    logic [lbss_pkg::IDX_W-1:0]      w_last_addr;
    lbss_pkg::t_mod_req              w_mod_req;
    lbss_pkg::t_mod_rsp              w_mod_rsp;

    lbss_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // Current pattern step and its duration during a rebuild.
    assign w_push      = lbss_pkg::push_at(r_scene, r_reserve, r_step);
    assign w_ms        = lbss_pkg::src_ms(r_cfg, w_push.src);
    assign w_sum       = r_acc + r_rd.dur;
    assign w_rem       = r_acc - r_elapsed;
    assign w_last_addr = lbss_pkg::IDX_W'(r_seg_count - 1'b1);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_period_ms <= 16'd1000;
            r_cfg.identify_half_ms <= 16'd250;
            r_cfg.long_pulse_ms    <= 16'd800;
            r_cfg.short_pulse_ms   <= 16'd200;
            r_cfg.pulse_gap_ms     <= 16'd300;
            r_cfg.series_pause_ms  <= 16'd2000;
            r_cfg.reserve_tick_ms  <= 16'd50;
            r_cfg.reserve_gap_ms   <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbss_pkg::CFG_NORMAL_PERIOD: r_cfg.normal_period_ms <= i_cfg_data;
                lbss_pkg::CFG_IDENTIFY_HALF: r_cfg.identify_half_ms <= i_cfg_data;
                lbss_pkg::CFG_LONG_PULSE:    r_cfg.long_pulse_ms    <= i_cfg_data;
                lbss_pkg::CFG_SHORT_PULSE:   r_cfg.short_pulse_ms   <= i_cfg_data;
                lbss_pkg::CFG_PULSE_GAP:     r_cfg.pulse_gap_ms     <= i_cfg_data;
                lbss_pkg::CFG_SERIES_PAUSE:  r_cfg.series_pause_ms  <= i_cfg_data;
                lbss_pkg::CFG_RESERVE_TICK:  r_cfg.reserve_tick_ms  <= i_cfg_data;
                lbss_pkg::CFG_RESERVE_GAP:   r_cfg.reserve_gap_ms   <= i_cfg_data;
            endcase
        end
    end

    // Sequencer: rebuild, optional modulo reduction, segment walk and result load.
    always_comb begin
        n_state       = r_state;
        n_scene       = r_scene;
        n_reserve     = r_reserve;
        n_level_valid = r_level_valid;
        n_last_level  = r_last_level;
        n_cycle_start = r_cycle_start;
        n_cycle_len   = r_cycle_len;
        n_seg_count   = r_seg_count;
        n_out_valid   = r_out_valid;
        n_out_word    = r_out_word;
        n_step        = r_step;
        n_pend        = r_pend;
        n_now         = r_now;
        n_elapsed     = r_elapsed;
        n_acc         = r_acc;
        n_idx         = r_idx;
        n_cur_on      = r_cur_on;
        n_emit_on     = r_emit_on;
        n_emit_delay  = r_emit_delay;
        w_mem_we      = 1'b0;
        w_mem_addr    = w_last_addr;
        w_mod_req     = '{start: 1'b0, dividend: r_elapsed, divisor: r_cycle_len};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.action == lbss_pkg::ACT_SET) begin
                        if (i_in_word.scene != r_scene || i_in_word.reserve != r_reserve) begin
                            n_scene       = i_in_word.scene;
                            n_reserve     = i_in_word.reserve;
                            n_cycle_start = i_in_word.now_ms;
                            n_level_valid = 1'b0;
                            n_seg_count   = '0;
                            n_cycle_len   = '0;
                            n_step        = '0;
                            n_state       = ST_BUILD;
                        end
                    end else if (r_seg_count == '0 || r_cycle_len == '0) begin
                        n_emit_on    = 1'b0;
                        n_emit_delay = '0;
                        n_state      = ST_EMIT;
                    end else begin
                        n_now     = i_in_word.now_ms;
                        n_elapsed = i_in_word.now_ms - r_cycle_start;
                        n_state   = ST_CHECK;
                    end
                end
            end
            ST_BUILD: begin
                if (w_push.valid) begin
                    // Zero-length steps and steps past a full table are dropped.
                    if (w_ms != '0 && r_seg_count < lbss_pkg::CNT_W'(lbss_pkg::MAX_SEGMENTS)) begin
                        if (r_seg_count != '0 && r_pend.on == w_push.on) begin
                            n_pend.dur = r_pend.dur + lbss_pkg::TIME_W'(w_ms);
                        end else begin
                            w_mem_we    = (r_seg_count != '0);
                            n_pend      = '{on: w_push.on, dur: lbss_pkg::TIME_W'(w_ms)};
                            n_seg_count = r_seg_count + 1'b1;
                        end
                        n_cycle_len = r_cycle_len + lbss_pkg::TIME_W'(w_ms);
                    end
                    n_step = r_step + 1'b1;
                end else begin
                    // Flush the segment still held open for merging.
                    w_mem_we = (r_seg_count != '0);
                    n_state  = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (r_elapsed >= r_cycle_len) begin
                    w_mod_req.start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_idx   = '0;
                    n_acc   = '0;
                    n_state = ST_RD;
                end
            end
            ST_DIV: begin
                if (w_mod_rsp.done) begin
                    // Start plus elapsed is now, so the new start is now minus the remainder.
                    n_cycle_start = r_now - w_mod_rsp.rem;
                    n_elapsed     = w_mod_rsp.rem;
                    n_idx         = '0;
                    n_acc         = '0;
                    n_state       = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_acc    = w_sum;
                n_cur_on = r_rd.on;
                n_state  = ST_TST;
            end
            ST_TST: begin
                if (r_elapsed < r_acc) begin
                    n_emit_on    = r_cur_on;
                    n_emit_delay = (w_rem == '0) ? lbss_pkg::TIME_W'(1) : w_rem;
                    n_state      = ST_EMIT;
                end else if (lbss_pkg::CNT_W'(r_idx + 1'b1) >= r_seg_count) begin
                    // Walked past the last segment: keep its level, retry in 1 ms.
                    n_emit_on    = r_cur_on;
                    n_emit_delay = lbss_pkg::TIME_W'(1);
                    n_state      = ST_EMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{led_level:   r_emit_on,
                                    level_event: ~(r_level_valid && r_last_level == r_emit_on),
                                    delay_ms:    r_emit_delay};
                    n_level_valid = 1'b1;
                    n_last_level  = r_emit_on;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_scene       <= lbss_pkg::SC_NORMAL;
            r_reserve     <= 1'b0;
            r_level_valid <= 1'b0;
            r_last_level  <= 1'b0;
            r_cycle_start <= '0;
            r_cycle_len   <= '0;
            r_seg_count   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_scene       <= n_scene;
            r_reserve     <= n_reserve;
            r_level_valid <= n_level_valid;
            r_last_level  <= n_last_level;
            r_cycle_start <= n_cycle_start;
            r_cycle_len   <= n_cycle_len;
            r_seg_count   <= n_seg_count;
            r_out_valid   <= n_out_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_out_word   <= n_out_word;
        r_step       <= n_step;
        r_pend       <= n_pend;
        r_now        <= n_now;
        r_elapsed    <= n_elapsed;
        r_acc        <= n_acc;
        r_idx        <= n_idx;
        r_cur_on     <= n_cur_on;
        r_emit_on    <= n_emit_on;
        r_emit_delay <= n_emit_delay;
    end

    // Segment memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= r_pend;
        end
        r_rd <= r_mem[r_idx[lbss_pkg::IDX_W-1:0]];
    end

`ifndef ASSERT_OFF
    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_count <= lbss_pkg::CNT_W'(lbss_pkg::MAX_SEGMENTS))
        else $error("segment count beyond table size");

    // Outside a rebuild an empty table and a zero cycle length go together.
    a_len_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((r_seg_count == '0) == (r_cycle_len == '0)))
        else $error("cycle length disagrees with segment count");

    // A zero delay only comes with the LED off.
    a_zero_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.delay_ms == '0) |-> !o_out_word.led_level)
        else $error("zero delay with LED on");

    // Loading a result records the driven level.
    a_level_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && (!r_out_valid || !i_out_stall))
        |=> (r_level_valid && r_last_level == o_out_word.led_level && o_out_valid))
        else $error("level tracking not updated on result");

    // The walk never reads beyond the filled part of the table.
    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_idx < r_seg_count))
        else $error("segment read beyond fill count");
`endif

endmodule
